// File: design/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg: shared types and constants of the vertex transform
// Fixed-point formats, derived datapath widths, and the item structs.
// ----------------------------------------------------------------------------
package hvt_pkg;

  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 8;
  localparam int WEIGHT_BITS = 16;
  localparam int NUM_ROWS    = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = NUM_ROWS * WEIGHT_BITS;

  // Product of a coordinate and a weight, and the scaled translation term.
  localparam int PROD_W  = COORD_BITS + WEIGHT_BITS;
  localparam int TRANS_W = WEIGHT_BITS + FRAC_BITS;
  localparam int SUM_W   = ((PROD_W > TRANS_W) ? PROD_W : TRANS_W) + 2;
  // Quotient holds 0 .. 2^COORD_BITS; remainder covers the shifted divisor.
  localparam int QUO_W   = COORD_BITS + 1;
  localparam int REM_W   = SUM_W + FRAC_BITS + COORD_BITS + 2;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_X = 3'd0,
    REG_COEF_Y = 3'd1,
    REG_COEF_Z = 3'd2,
    REG_COEF_W = 3'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic signed [COORD_BITS-1:0] in_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic                         w_was_zero;
    logic                         saturated;
  } vertex_t;

endpackage

// File: design/homogeneous_vertex_transform_core.sv
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_core: 4x4 transform with perspective divide
// Multiplies (x, y, z, 1) by the weight matrix and divides x, y, z by w.
// ----------------------------------------------------------------------------
// Stages from an accepted point to its vertex: multiply, sum, magnitude,
// range check, one restoring divide stage per quotient bit, and the
// clamp/output register.
// Throughput: one item per cycle; the whole pipeline holds while dst_stall
// keeps a finished vertex waiting in the output register.
// Reset (rst, synchronous): pipeline emptied, weights set to identity.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_core
  import hvt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_stall,
  input  point_t                src_item,
  output logic                  dst_valid,
  input  logic                  dst_stall,
  output vertex_t               dst_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NDIV = COORD_BITS + 1;
  localparam logic [QUO_W-1:0] CAP  = QUO_W'(1) << COORD_BITS;
  localparam logic [QUO_W-1:0] HALF = QUO_W'(1) << (COORD_BITS - 1);

  // Weights. The user writes only while the pipeline is empty; unenforced.
  logic [CFG_DATA_W-1:0] coef [NUM_ROWS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        coef[r] <= CFG_DATA_W'(1 << FRAC_BITS) << (r * WEIGHT_BITS);
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COEF_X: coef[0] <= cfg_data;
        REG_COEF_Y: coef[1] <= cfg_data;
        REG_COEF_Z: coef[2] <= cfg_data;
        REG_COEF_W: coef[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // One global advance: every stage moves together unless the output
  // register holds a vertex that the sink is refusing.
  logic adv;
  assign adv       = !(dst_valid && dst_stall);
  assign src_stall = !adv;

  // Stage 1: the twelve coordinate products and the translation terms.
  logic signed [PROD_W-1:0]  pt [3];
  logic signed [PROD_W-1:0]  prod [NUM_ROWS][3];
  logic signed [TRANS_W-1:0] trans [NUM_ROWS];
  logic                      v1;

  always_comb begin
    pt[0] = PROD_W'(src_item.in_x);
    pt[1] = PROD_W'(src_item.in_y);
    pt[2] = PROD_W'(src_item.in_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= src_valid;
    end
    if (adv) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= pt[c] *
            PROD_W'($signed(coef[r][c*WEIGHT_BITS +: WEIGHT_BITS]));
        end
        trans[r] <= TRANS_W'($signed(coef[r][3*WEIGHT_BITS +: WEIGHT_BITS]))
                    <<< FRAC_BITS;
      end
    end
  end

  // Stage 2: row sums, exact with 2*FRAC_BITS fraction bits.
  logic signed [SUM_W-1:0] sum [NUM_ROWS];
  logic                    v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        sum[r] <= SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) +
                  SUM_W'(prod[r][2]) + SUM_W'(trans[r]);
      end
    end
  end

  // Stage 3: signs and magnitudes; the undivided result for a zero w.
  logic [SUM_W-1:0] mag3 [3];
  logic [SUM_W-1:0] wmag3;
  logic [QUO_W-1:0] qz3 [3];
  logic [2:0]       neg3;
  logic             wneg3, wzero3, v3;
  logic [SUM_W-1:0] shr [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      shr[k] = (sum[k][SUM_W-1] ? -sum[k] : sum[k]) >> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        neg3[k] <= sum[k][SUM_W-1];
        mag3[k] <= sum[k][SUM_W-1] ? -sum[k] : sum[k];
        qz3[k]  <= (shr[k] > SUM_W'(CAP)) ? CAP : shr[k][QUO_W-1:0];
      end
      wneg3  <= sum[3][SUM_W-1];
      wzero3 <= (sum[3] == '0);
      wmag3  <= sum[3][SUM_W-1] ? -sum[3] : sum[3];
    end
  end

  // Stage 4 feeds the divider: dividend mag*2^FRAC_BITS, and a flag for a
  // quotient that already reaches 2^(COORD_BITS+1) and so clamps anyway.
  // Index j of these arrays is the input of divider stage j.
  logic [REM_W-1:0] rem  [NDIV+1][3];
  logic [QUO_W-1:0] quo  [NDIV+1][3];
  logic [QUO_W-1:0] qz   [NDIV+1][3];
  logic [2:0]       ovf  [NDIV+1];
  logic [2:0]       neg  [NDIV+1];
  logic [SUM_W-1:0] dv   [NDIV+1];
  logic             wneg [NDIV+1];
  logic             wzero[NDIV+1];
  logic             dvld [NDIV+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld[0] <= 1'b0;
    end else if (adv) begin
      dvld[0] <= v3;
    end
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        rem[0][k] <= REM_W'(mag3[k]) << FRAC_BITS;
        quo[0][k] <= '0;
        qz[0][k]  <= qz3[k];
        ovf[0][k] <= (REM_W'(mag3[k]) << FRAC_BITS) >=
                     (REM_W'(wmag3) << (COORD_BITS + 1));
      end
      neg[0]   <= neg3;
      dv[0]    <= wmag3;
      wneg[0]  <= wneg3;
      wzero[0] <= wzero3;
    end
  end

  // Restoring divide, one quotient bit per stage, most significant first.
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    localparam int BIT = COORD_BITS - j;
    logic [REM_W:0] trial [3];

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = {1'b0, rem[j][k]} - ((REM_W+1)'(dv[j]) << BIT);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[j+1] <= 1'b0;
      end else if (adv) begin
        dvld[j+1] <= dvld[j];
      end
      if (adv) begin
        for (int k = 0; k < 3; k++) begin
          if (!trial[k][REM_W]) begin
            rem[j+1][k]      <= trial[k][REM_W-1:0];
            quo[j+1][k]      <= quo[j][k] | (QUO_W'(1) << BIT);
          end else begin
            rem[j+1][k]      <= rem[j][k];
            quo[j+1][k]      <= quo[j][k];
          end
          qz[j+1][k] <= qz[j][k];
        end
        ovf[j+1]   <= ovf[j];
        neg[j+1]   <= neg[j];
        dv[j+1]    <= dv[j];
        wneg[j+1]  <= wneg[j];
        wzero[j+1] <= wzero[j];
      end
    end
  end

  // Last stage: pick the quotient, apply the sign and clamp to the range.
  logic [QUO_W-1:0]      qsel [3];
  logic [2:0]            nsel, clip;
  logic [COORD_BITS-1:0] res [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (wzero[NDIV]) begin
        qsel[k] = qz[NDIV][k];
        nsel[k] = neg[NDIV][k];
      end else begin
        qsel[k] = ovf[NDIV][k] ? CAP : quo[NDIV][k];
        nsel[k] = neg[NDIV][k] ^ wneg[NDIV];
      end
      if (nsel[k] && qsel[k] != '0) begin
        clip[k] = qsel[k] > HALF;
        res[k]  = clip[k] ? COORD_BITS'(HALF) : COORD_BITS'(-qsel[k]);
      end else begin
        clip[k] = qsel[k] > HALF - 1'b1;
        res[k]  = clip[k] ? COORD_BITS'(HALF - 1'b1) : qsel[k][COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (adv) begin
      dst_valid <= dvld[NDIV];
    end
    if (adv) begin
      dst_item.out_x      <= res[0];
      dst_item.out_y      <= res[1];
      dst_item.out_z      <= res[2];
      dst_item.w_was_zero <= wzero[NDIV];
      dst_item.saturated  <= |clip;
    end
  end

endmodule

// File: design/hvt_checker.sv
// ----------------------------------------------------------------------------
// hvt_checker: port-level checks of the vertex transform
// Hold under stall on both channels, stall relation, configuration
// acceptance, and saturation bounds.
// ----------------------------------------------------------------------------
module hvt_checker
  import hvt_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    src_valid,
  input logic    src_stall,
  input point_t  src_item,
  input logic    dst_valid,
  input logic    dst_stall,
  input vertex_t dst_item,
  input logic    cfg_valid,
  input logic    cfg_ready
);

  localparam logic signed [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

  // A refused vertex stays on the port unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_item))
    else $error("vertex changed while stalled");

  // A point that is held off stays on the source port unchanged.
  a_src_hold: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_stall |=> src_valid && $stable(src_item))
    else $error("point changed while stalled");

  // The source is held off exactly while a finished vertex is refused.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    src_stall == (dst_valid && dst_stall))
    else $error("source stall does not follow output stall");

  // Register writes are always taken in the cycle they are offered.
  a_cfg_accept: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write not accepted");

  // A saturated vertex has at least one component on a range bound.
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_item.saturated |->
      (dst_item.out_x == MAXV || dst_item.out_x == MINV ||
       dst_item.out_y == MAXV || dst_item.out_y == MINV ||
       dst_item.out_z == MAXV || dst_item.out_z == MINV))
    else $error("saturated flag without a clamped component");

endmodule

bind homogeneous_vertex_transform_core hvt_checker u_hvt_checker (.*);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for homogeneous_vertex_transform_core
// Drives points through the valid/stall source channel and predicts every
// untyped vertex in SystemVerilog. Results are compared field by field,
// in order. Weight matrices are changed through the configuration channel
// between phases, while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
  import hvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_DRAIN    = 30;    // longer than the core's pipeline latency
  localparam int WATCHDOG_MAX  = 2000;  // cycles without any handshake
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_POINTS  = 95;
  localparam int FIRST_UNUSED_INDEX = NUM_ROWS;
  localparam logic [63:0] ONE_Q88 = 64'd256;

  // Each directed row names the weight matrix it runs under. Where the result
  // is obvious the expected vertex is typed in; otherwise the model predicts.
  typedef struct packed {
    logic [2:0] mat;
    point_t     pt;
    logic       typed;
    vertex_t    v;
  } directed_row_t;

  // Matrices: identity, w forced to zero, tiny w, all largest weights, all
  // most negative weights, all minus one LSB, and a simple perspective row.
  localparam logic [63:0] DIR_MATS [7][4] = '{
    '{ONE_Q88, ONE_Q88 << 16, ONE_Q88 << 32, ONE_Q88 << 48},
    '{ONE_Q88, ONE_Q88 << 16, ONE_Q88 << 32, 64'd0},
    '{ONE_Q88, ONE_Q88 << 16, ONE_Q88 << 32, 64'd1 << 48},
    '{64'h7FFF7FFF7FFF7FFF, 64'h7FFF7FFF7FFF7FFF, 64'h7FFF7FFF7FFF7FFF, 64'h7FFF7FFF7FFF7FFF},
    '{64'h8000800080008000, 64'h8000800080008000, 64'h8000800080008000, 64'h8000800080008000},
    '{64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF},
    '{ONE_Q88, ONE_Q88 << 16, ONE_Q88 << 32, 64'h0100_0100_0000_0000}
  };

  localparam int DIR_N = 17;
  localparam directed_row_t DIR_ROWS [DIR_N] = '{
    '{3'd0, '{16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0}},
    '{3'd0, '{16'sd32767, 16'sd32767, 16'sd32767}, 1'b1,
      '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 1'b0}},
    '{3'd0, '{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b1,
      '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b0}},
    '{3'd0, '{16'sd256, -16'sd256, 16'sd1}, 1'b1,
      '{16'sd256, -16'sd256, 16'sd1, 1'b0, 1'b0}},
    '{3'd0, '{-16'sd1, 16'sd1, 16'sh5555}, 1'b1,
      '{-16'sd1, 16'sd1, 16'sh5555, 1'b0, 1'b0}},
    '{3'd1, '{16'sd256, -16'sd512, 16'sd0}, 1'b1,
      '{16'sd256, -16'sd512, 16'sd0, 1'b1, 1'b0}},
    '{3'd1, '{16'sd32767, -16'sd32768, 16'sd1}, 1'b1,
      '{16'sd32767, -16'sd32768, 16'sd1, 1'b1, 1'b0}},
    '{3'd2, '{16'sd1, -16'sd1, 16'sd0}, 1'b0, '0},
    '{3'd2, '{16'sd32767, -16'sd32768, 16'sd100}, 1'b0, '0},
    '{3'd3, '{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0},
    '{3'd3, '{-16'sd32768, 16'sd1, -16'sd5}, 1'b0, '0},
    '{3'd4, '{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0},
    '{3'd4, '{16'sd32767, 16'sd0, 16'sd0}, 1'b0, '0},
    '{3'd5, '{16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{3'd5, '{16'sd1234, -16'sd77, 16'sd9000}, 1'b0, '0},
    '{3'd6, '{16'sd512, 16'sd512, 16'sd256}, 1'b0, '0},
    '{3'd6, '{16'sd512, -16'sd512, -16'sd255}, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       src_valid = 1'b0;
  logic       src_stall;
  point_t     src_item = '0;
  logic       dst_valid;
  logic       dst_stall = 1'b0;
  vertex_t    dst_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Our copy of the weight registers, kept in step with every accepted write.
  logic [63:0] weight_rows [NUM_ROWS];
  vertex_t     pending_vertices [$];
  bit          no_idle = 1'b0;
  int          errors = 0;
  int          points_sent = 0;
  int          vertices_checked = 0;
  int          zero_w_seen = 0;
  int          clamps_seen = 0;
  int          idle_cycles = 0;
  int          dst_hold = 0;

  always #10 clk = ~clk;

  homogeneous_vertex_transform_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic longint weight_at(int row, int col);
    return longint'($signed(weight_rows[row][col*WEIGHT_BITS +: WEIGHT_BITS]));
  endfunction

  // Long division of (n << FRAC_BITS) by d, stopping as soon as the quotient
  // passes 2^COORD_BITS, since it will be clamped anyway.
  function automatic longint unsigned divide_scaled(longint unsigned n, longint unsigned d);
    longint unsigned cap;
    longint unsigned q;
    longint unsigned r;
    cap = 64'd1 << COORD_BITS;
    q = n / d;
    r = n % d;
    if (q > cap) return cap;
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
      if (q > cap) return cap;
    end
    return q;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(bit neg, longint unsigned mag,
                                                        ref bit sat);
    longint unsigned half;
    half = 64'd1 << (COORD_BITS - 1);
    if (!neg) begin
      if (mag > half - 1) begin
        sat = 1'b1;
        mag = half - 1;
      end
      return mag[COORD_BITS-1:0];
    end
    if (mag > half) begin
      sat = 1'b1;
      mag = half;
    end
    return -mag[COORD_BITS-1:0];
  endfunction

  function automatic vertex_t transform_point(point_t p);
    longint coord [3];
    longint sums [NUM_ROWS];
    longint unsigned wmag;
    longint unsigned mag;
    longint unsigned q;
    bit neg;
    bit sat;
    vertex_t v;
    logic [COORD_BITS-1:0] outs [3];
    coord[0] = longint'(p.in_x);
    coord[1] = longint'(p.in_y);
    coord[2] = longint'(p.in_z);
    sat = 1'b0;
    for (int r = 0; r < NUM_ROWS; r++)
      sums[r] = coord[0] * weight_at(r, 0) + coord[1] * weight_at(r, 1)
              + coord[2] * weight_at(r, 2) + (weight_at(r, 3) <<< FRAC_BITS);
    wmag = (sums[3] < 0) ? -sums[3] : sums[3];
    for (int k = 0; k < 3; k++) begin
      neg = sums[k] < 0;
      mag = neg ? -sums[k] : sums[k];
      if (sums[3] == 0) begin
        q = mag >> FRAC_BITS;
      end else begin
        q = divide_scaled(mag, wmag);
        neg = neg != (sums[3] < 0);
      end
      outs[k] = clamp_coord(neg && q != 0, q, sat);
    end
    v.out_x = outs[0];
    v.out_y = outs[1];
    v.out_z = outs[2];
    v.w_was_zero = sums[3] == 0;
    v.saturated = sat;
    return v;
  endfunction

  // Waits until no vertex is outstanding and the pipeline has drained.
  task automatic wait_empty();
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // Offers one write and returns on the edge that takes it; valid stays up
  // so writes can follow back to back.
  task automatic write_reg(cfg_index_t idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_ROWS) weight_rows[idx] = data;
  endtask

  // Loads a full matrix, sometimes followed by a write to an unused index
  // that the block has to ignore.
  task automatic load_matrix(logic [63:0] rows [4]);
    for (int r = 0; r < NUM_ROWS; r++) write_reg(reg_index_t'(r), rows[r]);
    if ($urandom_range(0, 1))
      write_reg(cfg_index_t'($urandom_range(FIRST_UNUSED_INDEX, 7)),
                {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Presents one point; the expected vertex is queued at the edge that
  // accepts it. The task returns on that edge so the next item can follow.
  task automatic send_point(point_t p, bit typed, vertex_t typed_v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= p;
    do @(posedge clk); while (src_stall);
    pending_vertices.push_back(typed ? typed_v : transform_point(p));
    points_sent++;
  endtask

  function automatic logic [15:0] random_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 2047) - 1024);
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(0, 511) - 256);
    endcase
  endfunction

  function automatic logic [15:0] small_weight();
    return 16'($urandom_range(0, 1023) - 512);
  endfunction

  // Random matrix: small-weight rows with a positive w offset, plus fully
  // random words, zero w, the extreme patterns and a perturbed perspective matrix.
  task automatic random_matrix(output logic [63:0] rows [4]);
    int kind;
    kind = $urandom_range(0, 5);
    for (int r = 0; r < NUM_ROWS; r++) begin
      case (kind)
        0, 1: begin
          rows[r] = {small_weight(), small_weight(), small_weight(), small_weight()};
          if (r == 3) rows[r][63:48] = 16'($urandom_range(64, 1023));
        end
        2: rows[r] = {$urandom, $urandom};
        3: rows[r] = (r == 3) ? 64'd0 : {small_weight(), small_weight(), small_weight(),
                                         small_weight()};
        4: rows[r] = DIR_MATS[$urandom_range(3, 5)][r];
        default: rows[r] = DIR_MATS[6][r] ^ {48'd0, 16'($urandom_range(0, 15))};
      endcase
    end
  endtask

  // Sink side: checks each accepted vertex and draws a new stall length.
  always @(posedge clk) begin
    vertex_t want;
    if (rst) begin
      dst_stall <= 1'b0;
    end else begin
      if (dst_valid && !dst_stall) begin
        if (pending_vertices.size() == 0) begin
          $error("vertex arrived with none expected: %h", dst_item);
          errors++;
        end else begin
          want = pending_vertices.pop_front();
          vertices_checked++;
          if (dst_item.w_was_zero) zero_w_seen++;
          if (dst_item.saturated) clamps_seen++;
          if (dst_item.out_x !== want.out_x) begin
            $error("out_x expected %0d got %0d", want.out_x, dst_item.out_x);
            errors++;
          end
          if (dst_item.out_y !== want.out_y) begin
            $error("out_y expected %0d got %0d", want.out_y, dst_item.out_y);
            errors++;
          end
          if (dst_item.out_z !== want.out_z) begin
            $error("out_z expected %0d got %0d", want.out_z, dst_item.out_z);
            errors++;
          end
          if (dst_item.w_was_zero !== want.w_was_zero) begin
            $error("w_was_zero expected %0b got %0b", want.w_was_zero, dst_item.w_was_zero);
            errors++;
          end
          if (dst_item.saturated !== want.saturated) begin
            $error("saturated expected %0b got %0b", want.saturated, dst_item.saturated);
            errors++;
          end
        end
        dst_hold = no_idle ? 0 : $urandom_range(0, 4);
      end else if (dst_hold > 0) begin
        dst_hold--;
      end
      dst_stall <= dst_hold > 0;
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (dst_valid && !dst_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_MAX) begin
      $display("watchdog expired with %0d vertices outstanding", pending_vertices.size());
      $display("homogeneous_vertex_transform_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [63:0] rows [4];
    logic [2:0]  cur_mat;
    point_t      p;
    for (int r = 0; r < NUM_ROWS; r++) weight_rows[r] = DIR_MATS[0][r];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: identity after reset first, then the special matrices.
    cur_mat = 3'd0;
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].mat != cur_mat) begin
        src_valid <= 1'b0;
        wait_empty();
        cur_mat = DIR_ROWS[i].mat;
        rows = DIR_MATS[cur_mat];
        load_matrix(rows);
      end
      send_point(DIR_ROWS[i].pt, DIR_ROWS[i].typed, DIR_ROWS[i].v);
    end

    // Random part: one matrix per phase, some phases run with no idling.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      src_valid <= 1'b0;
      wait_empty();
      random_matrix(rows);
      load_matrix(rows);
      no_idle = (ph % 4) == 2;
      for (int n = 0; n < PHASE_POINTS; n++) begin
        // Hold off once mid-run until every vertex has come back.
        if (ph == 1 && n == PHASE_POINTS / 2) begin
          src_valid <= 1'b0;
          while (pending_vertices.size() != 0) @(posedge clk);
        end
        p.in_x = random_coord();
        p.in_y = random_coord();
        p.in_z = random_coord();
        send_point(p, 1'b0, '0);
      end
    end
    src_valid <= 1'b0;
    no_idle = 1'b0;
    wait_empty();

    $display("covered %0d points and %0d vertices over %0d matrices", points_sent,
             vertices_checked, RANDOM_PHASES + 7);
    $display("vertices with zero w: %0d, with clamping: %0d", zero_w_seen, clamps_seen);
    if (errors == 0) begin
      $display("homogeneous_vertex_transform_core: match");
    end else begin
      $display("homogeneous_vertex_transform_core: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
design/hvt_pkg.sv
design/homogeneous_vertex_transform_core.sv
design/hvt_checker.sv
tb/sv/testbench.sv
